FILE: sv/crcchk_pkg.sv
`timescale 1ns / 1ps

package crcchk_pkg;

    localparam int MAX_DEVICES = 8;
    // The device counter is 3 bits wide, so never go past 8 devices.
    localparam int DEV_LIMIT   = (MAX_DEVICES < 8) ? MAX_DEVICES : 8;

    localparam int CNT_W       = 4;
    localparam int DEV_W       = 3;
    localparam int POS_W       = 3;
    localparam int CRC_W       = 15;
    localparam int DATA_W      = 48;

    localparam logic [CRC_W-1:0] CRC_SEED   = 15'd16;
    localparam logic [15:0]      CRC_POLY   = 16'h4599;
    localparam logic [15:0]      CRC_TOPBIT = 16'h4000;
    localparam logic [CNT_W-1:0] CNT_RESET  = 4'd1;

    // byte positions inside one group
    localparam logic [POS_W-1:0] POS_CHECK_HI = 3'd6;
    localparam logic [POS_W-1:0] POS_CHECK_LO = 3'd7;

    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0]       rx_byte;
        logic             start;
        logic [POS_W-1:0] pos;
    } t_qitem;

    function automatic logic [CRC_W-1:0] crc15_entry(input logic [7:0] idx);
        logic [15:0] r;
        r = {1'b0, idx, 7'd0};
        for (int b = 0; b < 8; b++) begin
            if ((r & CRC_TOPBIT) != 16'd0) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r[CRC_W-1:0];
    endfunction

    function automatic logic [CRC_W-1:0] crc15_update(input logic [CRC_W-1:0] crc,
                                                       input logic [7:0] data);
        logic [7:0] idx;
        idx = crc[14:7] ^ data;
        return {crc[6:0], 8'd0} ^ crc15_entry(idx);
    endfunction

endpackage

FILE: sv/crcchk_front.sv
`timescale 1ns / 1ps

module crcchk_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_start_req,
    input  logic                  i_q_full,
    output logic                  o_in_stall,
    output logic                  o_push,
    output crcchk_pkg::t_qitem    o_item
);
    import crcchk_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] cur_pos;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    // start forces the beat to data byte 0
    assign cur_pos = i_start_req ? '0 : r_pos;
    assign n_pos   = cur_pos + POS_W'(1);

    assign o_item.rx_byte = i_rx_byte;
    assign o_item.start   = i_start_req;
    assign o_item.pos     = cur_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: sv/crcchk_fifo.sv
`timescale 1ns / 1ps

module crcchk_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  crcchk_pkg::t_qitem    i_item,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output crcchk_pkg::t_qitem    o_item
);
    import crcchk_pkg::*;

    t_qitem         r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_count;

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + QCW'(1))
        else $error("push lost");

endmodule

FILE: sv/crcchk_back.sv
`timescale 1ns / 1ps

module crcchk_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [crcchk_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                            i_q_valid,
    input  crcchk_pkg::t_qitem              i_item,
    output logic                            o_pop,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [crcchk_pkg::DATA_W-1:0]   o_group_data,
    output logic [crcchk_pkg::DEV_W-1:0]    o_device_index,
    output logic                            o_check_ok,
    output logic                            o_last_group,
    output logic                            o_any_error
);
    import crcchk_pkg::*;

    logic [CNT_W-1:0]  r_dev_count;
    logic [CRC_W-1:0]  r_crc;
    logic [DATA_W-1:0] r_data;
    logic [7:0]        r_hi;
    logic [DEV_W-1:0]  r_dev;
    logic              r_err;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [DEV_W-1:0]  r_out_dev;
    logic              r_out_ok;
    logic              r_out_last;
    logic              r_out_err;

    logic [CRC_W-1:0]  crc_base;
    logic [DATA_W-1:0] data_base;
    logic [7:0]        hi_base;
    logic [DEV_W-1:0]  dev_base;
    logic              err_base;
    logic [CNT_W-1:0]  eff_count;
    logic              is_final;
    logic              load;
    logic              ok;
    logic              last;

    // a start beat begins a fresh read before its byte is taken
    assign crc_base  = i_item.start ? CRC_SEED : r_crc;
    assign data_base = i_item.start ? '0 : r_data;
    assign hi_base   = i_item.start ? '0 : r_hi;
    assign dev_base  = i_item.start ? '0 : r_dev;
    assign err_base  = i_item.start ? 1'b0 : r_err;

    always_comb begin
        if (r_dev_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (r_dev_count > CNT_W'(DEV_LIMIT)) begin
            eff_count = CNT_W'(DEV_LIMIT);
        end else begin
            eff_count = r_dev_count;
        end
    end

    assign is_final = (i_item.pos == POS_CHECK_LO);
    // hold the final byte while the output register is still owed to the receiver
    assign o_pop    = i_q_valid & ~(is_final & r_out_valid & i_out_stall);
    assign load     = o_pop & is_final;
    assign ok       = ({hi_base, i_item.rx_byte} == {crc_base, 1'b0});
    assign last     = (({1'b0, dev_base} + CNT_W'(1)) >= eff_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_count <= CNT_RESET;
        end else if (i_cfg_valid) begin
            r_dev_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_SEED;
            r_data <= '0;
            r_hi  <= '0;
            r_dev <= '0;
            r_err <= 1'b0;
        end else if (o_pop) begin
            if (i_item.pos < POS_CHECK_HI) begin
                r_crc  <= crc15_update(crc_base, i_item.rx_byte);
                r_data <= {data_base[DATA_W-9:0], i_item.rx_byte};
                r_hi   <= hi_base;
                r_dev  <= dev_base;
                r_err  <= err_base;
            end else if (i_item.pos == POS_CHECK_HI) begin
                r_crc  <= crc_base;
                r_data <= data_base;
                r_hi   <= i_item.rx_byte;
                r_dev  <= dev_base;
                r_err  <= err_base;
            end else begin
                r_crc  <= CRC_SEED;
                r_data <= '0;
                r_hi   <= '0;
                r_dev  <= last ? '0 : dev_base + DEV_W'(1);
                r_err  <= last ? 1'b0 : (err_base | ~ok);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= data_base;
            r_out_dev  <= dev_base;
            r_out_ok   <= ok;
            r_out_last <= last;
            r_out_err  <= err_base | ~ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_group_data   = r_out_data;
    assign o_device_index = r_out_dev;
    assign o_check_ok     = r_out_ok;
    assign o_last_group   = r_out_last;
    assign o_any_error    = r_out_err;

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && last |=> r_dev == '0 && !r_err)
        else $error("read did not restart after last group");

    a_fail_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && !ok |=> o_any_error && !o_check_ok)
        else $error("failed check not flagged");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !load)
        else $error("pending result overwritten");

endmodule

FILE: sv/chain_readback_crc15_checker.sv
`timescale 1ns / 1ps

// Readback checker for a daisy chain of monitor devices.
// Input channel: one received byte per beat (i_rx_byte), with i_start_req set
// on the first byte of a read. Each device sends 8 bytes: 6 data bytes, then a
// CRC-15 check word, high byte first.
// Output channel: one result per completed group, carrying the 48 data bits,
// the device index, the check result, a last-group mark and the running error
// flag of the read.
// Config channel: i_cfg_data sets the device count per read (0 acts as 1,
// values above 8 act as 8). o_cfg_ready is always high; write only while idle.
// Throughput: one byte per cycle while o_in_stall is low. Each byte passes the
// classifier, a 2-entry queue and the CRC unit; a group's result is registered
// to o_out_valid when its last byte is popped, unless an earlier result is held.
// When the receiver stalls, the result holds in the output register; the
// CRC unit keeps taking data bytes and stops only at the next group's last
// byte, after which the queue fills and o_in_stall rises.
// Reset (synchronous, active low) empties the queue and output, seeds the CRC,
// clears the counters and error flag, and sets the device count to 1.
module chain_readback_crc15_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_start_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [crcchk_pkg::DATA_W-1:0]   o_group_data,
    output logic [crcchk_pkg::DEV_W-1:0]    o_device_index,
    output logic                            o_check_ok,
    output logic                            o_last_group,
    output logic                            o_any_error,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [crcchk_pkg::CNT_W-1:0]    i_cfg_data
);
    import crcchk_pkg::*;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;
    t_qitem front_item;
    t_qitem q_item;

    assign o_cfg_ready = 1'b1;

    crcchk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .i_start_req (i_start_req),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_item      (front_item)
    );

    crcchk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    crcchk_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_item         (q_item),
        .o_pop          (pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_group_data   (o_group_data),
        .o_device_index (o_device_index),
        .o_check_ok     (o_check_ok),
        .o_last_group   (o_last_group),
        .o_any_error    (o_any_error)
    );

endmodule

FILE: tb/sv/chain_readback_monitor.sv
`timescale 1ns / 1ps

package readback_crc_pkg;

    // Advance the CRC-15 by one byte, MSB first.
    function automatic logic [14:0] crc15_next(input logic [14:0] crc, input logic [7:0] b);
        logic [14:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[14] ^ b[k];
            c  = {c[13:0], 1'b0};
            if (fb) begin
                c = c ^ crcchk_pkg::CRC_POLY[14:0];
            end
        end
        return c;
    endfunction

endpackage

module chain_readback_monitor
    import crcchk_pkg::*;
    import readback_crc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_start_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [DATA_W-1:0] i_group_data,
    input  logic [DEV_W-1:0]  i_device_index,
    input  logic              i_check_ok,
    input  logic              i_last_group,
    input  logic              i_any_error,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [DEV_W-1:0]  dev;
        logic              ok;
        logic              last;
        logic              err;
    } group_result_t;

    group_result_t     expected_groups[$];

    logic [CRC_W-1:0]  crc;
    logic [POS_W-1:0]  pos;
    logic [DEV_W-1:0]  dev;
    logic [DATA_W-1:0] shift;
    logic [7:0]        check_hi;
    logic              err_seen;
    logic [CNT_W-1:0]  dev_count;

    task automatic check_field(input string what, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        group_result_t g;
        group_result_t want;
        int            chain_len;

        if (!i_rst_n) begin
            crc       = CRC_SEED;
            pos       = '0;
            dev       = '0;
            shift     = '0;
            check_hi  = '0;
            err_seen  = 1'b0;
            dev_count = CNT_RESET;
            expected_groups.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                dev_count = i_cfg_data;
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_groups.size() == 0) begin
                    $display("%0t: unexpected group result, data %h", $time, i_group_data);
                    o_fail_count++;
                end else begin
                    want = expected_groups.pop_front();
                    check_field("group_data", want.data, i_group_data);
                    check_field("device_index", 48'(want.dev), 48'(i_device_index));
                    check_field("check_ok", 48'(want.ok), 48'(i_check_ok));
                    check_field("last_group", 48'(want.last), 48'(i_last_group));
                    check_field("any_error", 48'(want.err), 48'(i_any_error));
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_start_req) begin
                    crc      = CRC_SEED;
                    pos      = '0;
                    dev      = '0;
                    shift    = '0;
                    check_hi = '0;
                    err_seen = 1'b0;
                end
                if (pos < POS_CHECK_HI) begin
                    crc   = crc15_next(crc, i_rx_byte);
                    shift = {shift[DATA_W-9:0], i_rx_byte};
                    pos   = pos + 3'd1;
                end else if (pos == POS_CHECK_HI) begin
                    check_hi = i_rx_byte;
                    pos      = POS_CHECK_LO;
                end else begin
                    // zero acts as one; never run past the counter range
                    chain_len = int'(dev_count);
                    if (chain_len == 0) chain_len = 1;
                    if (chain_len > DEV_LIMIT) chain_len = DEV_LIMIT;
                    g.data = shift;
                    g.dev  = dev;
                    g.ok   = ({check_hi, i_rx_byte} == {crc, 1'b0});
                    g.last = (int'(dev) + 1 >= chain_len);
                    if (!g.ok) err_seen = 1'b1;
                    g.err  = err_seen;
                    expected_groups.push_back(g);
                    crc      = CRC_SEED;
                    pos      = '0;
                    shift    = '0;
                    check_hi = '0;
                    if (g.last) begin
                        dev      = '0;
                        err_seen = 1'b0;
                    end else begin
                        dev = dev + 3'd1;
                    end
                end
            end
        end
        o_pending = expected_groups.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import crcchk_pkg::*;
    import readback_crc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [7:0]             i_rx_byte      = 8'd0;
    logic                   i_start_req    = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [DATA_W-1:0]      o_group_data;
    logic [DEV_W-1:0]       o_device_index;
    logic                   o_check_ok;
    logic                   o_last_group;
    logic                   o_any_error;
    logic                   i_cfg_valid    = 1'b0;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data     = '0;

    int                     fail_count;
    int                     pending_groups;
    int                     cycles         = 0;
    int                     sent           = 0;
    int                     stall_left     = 0;
    logic                   out_took       = 1'b0;
    logic                   quiet          = 1'b0;

    chain_readback_crc15_checker u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_start_req    (i_start_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_group_data   (o_group_data),
        .o_device_index (o_device_index),
        .o_check_ok     (o_check_ok),
        .o_last_group   (o_last_group),
        .o_any_error    (o_any_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    chain_readback_monitor u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_start_req    (i_start_req),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_group_data   (o_group_data),
        .i_device_index (o_device_index),
        .i_check_ok     (o_check_ok),
        .i_last_group   (o_last_group),
        .i_any_error    (o_any_error),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_groups)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[chain_readback_crc15_checker] ERROR");
            $finish;
        end
    end

    // Receiver: stall for a drawn number of cycles after each beat, and now and then
    // on its own.
    always @(posedge i_clk) out_took <= o_out_valid && !i_out_stall;

    always @(negedge i_clk) begin
        if (out_took) begin
            stall_left = quiet ? 0 : $urandom_range(0, 3);
        end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 3);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_start_req <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [15:0] good_word(input logic [DATA_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = CRC_SEED;
        for (int k = 5; k >= 0; k--) begin
            c = crc15_next(c, data[8*k +: 8]);
        end
        return {c, 1'b0};
    endfunction

    task automatic send_group(input logic [DATA_W-1:0] data, input logic [15:0] word,
                              input logic s);
        for (int k = 5; k >= 0; k--) begin
            put_byte(data[8*k +: 8], (k == 5) ? s : 1'b0);
        end
        put_byte(word[15:8], 1'b0);
        put_byte(word[7:0], 1'b0);
    endtask

    task automatic run_read(input int n);
        logic [DATA_W-1:0] data;
        logic [15:0]       word;
        logic              s;
        for (int d = 0; d < n; d++) begin
            data = {16'($urandom), 32'($urandom)};
            case ($urandom_range(0, 15))
                0:       data = '0;
                1:       data = '1;
                default: ;
            endcase
            word = good_word(data);
            case ($urandom_range(0, 9))
                0:       word = word ^ (16'd1 << $urandom_range(1, 15));
                1:       word = word | 16'd1;
                2:       word = 16'($urandom);
                default: ;
            endcase
            // mostly open a read with a start; rarely restart mid-read
            s = (d == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 30) == 0);
            send_group(data, word, s);
        end
    endtask

    // Hold the sender until every pending group is out, then let the pipe settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_groups != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] fixed_counts [5];
        logic [CNT_W-1:0] cnt;
        logic [DATA_W-1:0] data;
        int               chain_len;
        int               target;

        fixed_counts = '{4'd0, 4'd8, 4'd15, 4'd9, 4'd1};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all-zero data with a good word, all-ones data with a word that
        // has its low bit set, then a partial group cut short by a new start.
        send_group('0, good_word('0), 1'b1);
        send_group('1, 16'hFFFF, 1'b1);
        put_byte(8'hA5, 1'b1);
        put_byte(8'h5A, 1'b0);
        put_byte(8'hFF, 1'b0);
        data = 48'h0123_4567_89AB;
        send_group(data, good_word(data), 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            cnt = (ph < 5) ? fixed_counts[ph] : 4'($urandom_range(2, 7));
            write_count(cnt);
            chain_len = (cnt == 0) ? 1 : ((int'(cnt) > DEV_LIMIT) ? DEV_LIMIT : int'(cnt));
            quiet  = (ph % 3 == 2);
            target = sent + 160;
            while (sent < target) begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 7)) begin
                        put_byte(8'($urandom), $urandom_range(0, 3) == 0);
                    end
                end else if ($urandom_range(0, 5) == 0) begin
                    // short reads and reads that run past the last device
                    run_read($urandom_range(1, chain_len + 1));
                end else begin
                    run_read(chain_len);
                end
            end
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[chain_readback_crc15_checker] OK");
        end else begin
            $display("[chain_readback_crc15_checker] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/crcchk_pkg.sv
sv/crcchk_front.sv
sv/crcchk_fifo.sv
sv/crcchk_back.sv
sv/chain_readback_crc15_checker.sv
tb/sv/chain_readback_monitor.sv
tb/sv/tb_top.sv
